// ----- hdl/mzvs_pkg.sv -----
`timescale 1ns / 1ps

package mzvs_pkg;

	// command codes carried in a request
	typedef enum logic [2:0] {
		ACT_TICK         = 3'd0,
		ACT_ZONE_ON      = 3'd1,
		ACT_ZONE_OFF     = 3'd2,
		ACT_CLOSE_ALL    = 3'd3,
		ACT_NOTIFY_TASK  = 3'd4,
		ACT_CLEAR_TASK   = 3'd5,
		ACT_MANUAL_OPEN  = 3'd6,
		ACT_MANUAL_CLOSE = 3'd7
	} action_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK              = 3'd0,
		ST_INVALID_CHANNEL = 3'd1,
		ST_NOT_READY       = 3'd2,
		ST_BUSY            = 3'd3,
		ST_MASTER_DISABLED = 3'd4
	} status_t;

	// pending timed step of a valve sequence
	typedef enum logic [1:0] {
		PH_IDLE              = 2'd0,
		PH_ZONE_AFTER_MASTER = 2'd1,
		PH_MASTER_AFTER_ZONE = 2'd2,
		PH_ZONE_AFTER_CLOSE  = 2'd3
	} phase_t;

	// configuration register indexes
	localparam logic [2:0] CFG_MASTER_ENABLE = 3'd0;
	localparam logic [2:0] CFG_AUTO_MANAGE   = 3'd1;
	localparam logic [2:0] CFG_PRE_START     = 3'd2;
	localparam logic [2:0] CFG_POST_STOP     = 3'd3;
	localparam logic [2:0] CFG_GRACE         = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int MS_W       = 32;
	localparam int DELAY_MS_W = 18;
	localparam logic [DELAY_MS_W-1:0] MS_PER_S = 18'd1000;

	typedef struct packed {
		action_t     action;
		logic [7:0]  channel;
		logic [31:0] task_start_ms;
		logic        system_ready;
		logic        system_fault;
	} req_item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] zone_open_mask;
		logic       master_open;
		logic       watering;
		logic       clear_flow_count;
	} rsp_item_t;

endpackage

// ----- hdl/master_and_zone_valve_sequencer.sv -----
`timescale 1ns / 1ps

// Master and zone valve sequencer.
// Request channel (req_valid/req_ready/req_data) carries one command or one
// millisecond tick per request; every request yields exactly one result on
// the response channel (rsp_valid/rsp_ready/rsp_data), in request order.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data and are
// always accepted; indexes past the register list are ignored.
// Timed valve steps are counted in tick requests, so the block itself has
// no notion of wall time.
// Throughput: one request per cycle while the receiver takes each result;
// a request register feeds a single pass of compare/add logic that updates
// the valve state and loads the result register.
// When the receiver stalls, the result register holds and the request
// register still takes one more request; after that req_ready drops until
// the result is taken.
// Reset (arst_n low) closes all valves, clears uptime, task and timers, and
// loads the configuration defaults.
module master_and_zone_valve_sequencer #(
	parameter int ZONES      = 8,
	parameter int MAX_ACTIVE = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  mzvs_pkg::req_item_t           req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output mzvs_pkg::rsp_item_t           rsp_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mzvs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mzvs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mzvs_pkg::*;

	localparam int CH_W  = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int CNT_W = 4;

	// configuration registers
	logic       master_enable_q;
	logic       auto_manage_q;
	logic [8:0] pre_start_q;
	logic [8:0] post_stop_q;
	logic [7:0] grace_s_q;

	// request and result registers
	req_item_t req_s1;
	logic      valid_s1;
	rsp_item_t rsp_q;
	logic      rsp_valid_q;
	logic      advance;

	// valve state
	logic [MS_W-1:0]  uptime_q, next_task_q, close_ms_q, seq_deadline_q;
	logic [ZONES-1:0] zone_mask_q;
	logic             master_q, task_pending_q, armed_q;
	phase_t           phase_q;
	logic [CH_W-1:0]  seq_ch_q;

	// next state
	logic [MS_W-1:0]  uptime_d, next_task_d, close_ms_d, seq_deadline_d;
	logic [ZONES-1:0] zone_mask_d;
	logic             master_d, task_pending_d, armed_d;
	phase_t           phase_d;
	logic [CH_W-1:0]  seq_ch_d;
	rsp_item_t        rsp_d;

	// decoded request
	logic            automatic_mode;
	logic [MS_W-1:0] um;
	logic            busy_seq, seq_fire, ch_ok;
	logic [CH_W-1:0] ch_idx;
	logic [CNT_W-1:0] active_cnt;
	status_t         status_d;
	logic            do_tick, on_go, off_go, all_go, man_open, man_close, notify, clear;

	// delays in milliseconds
	logic                  pre_pos, pre_neg, post_pos, post_neg;
	logic [8:0]            pre_mag, post_mag;
	logic [DELAY_MS_W-1:0] pre_ms, post_ms, grace_ms;
	logic [MS_W-1:0]       limit_ms, until_ms, arm_delay;
	logic                  fire_close, near_task, do_arm;

	// handshakes
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_enable_q <= 1'b1;
			auto_manage_q   <= 1'b1;
			pre_start_q     <= 9'd3;
			post_stop_q     <= 9'd2;
			grace_s_q       <= 8'd5;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MASTER_ENABLE: master_enable_q <= cfg_data[0];
				CFG_AUTO_MANAGE:   auto_manage_q   <= cfg_data[0];
				CFG_PRE_START:     pre_start_q     <= cfg_data;
				CFG_POST_STOP:     post_stop_q     <= cfg_data;
				CFG_GRACE:         grace_s_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// delay magnitudes and timer compares
	always_comb begin
		automatic_mode = master_enable_q && auto_manage_q;
		pre_neg  = pre_start_q[8];
		pre_pos  = !pre_start_q[8] && (pre_start_q != 9'd0);
		post_neg = post_stop_q[8];
		post_pos = !post_stop_q[8] && (post_stop_q != 9'd0);
		pre_mag  = pre_neg ? (9'd0 - pre_start_q) : pre_start_q;
		post_mag = post_neg ? (9'd0 - post_stop_q) : post_stop_q;
		pre_ms   = DELAY_MS_W'(pre_mag) * MS_PER_S;
		post_ms  = DELAY_MS_W'(post_mag) * MS_PER_S;
		grace_ms = DELAY_MS_W'(grace_s_q) * MS_PER_S;
		um       = (req_s1.action == ACT_TICK) ? (uptime_q + 32'd1) : uptime_q;
		limit_ms = next_task_q + MS_W'(grace_ms);
		until_ms = next_task_q - um;
		fire_close = master_q && master_enable_q && (!task_pending_q || (um > limit_ms));
		near_task  = task_pending_q && (until_ms <= MS_W'(grace_ms));
		arm_delay  = near_task ? (until_ms + MS_W'(grace_ms)) : MS_W'(post_ms);
		do_arm     = near_task || post_pos;
	end

	// open zone count
	always_comb begin
		active_cnt = '0;
		for (int i = 0; i < ZONES; i++) begin
			active_cnt = active_cnt + CNT_W'(zone_mask_q[i]);
		end
	end

	// request decode and status
	always_comb begin
		busy_seq  = (phase_q != PH_IDLE);
		ch_ok     = (req_s1.channel < 8'(ZONES));
		ch_idx    = req_s1.channel[CH_W-1:0];
		status_d  = ST_OK;
		do_tick   = 1'b0;
		on_go     = 1'b0;
		off_go    = 1'b0;
		all_go    = 1'b0;
		man_open  = 1'b0;
		man_close = 1'b0;
		notify    = 1'b0;
		clear     = 1'b0;
		case (req_s1.action)
			ACT_TICK: do_tick = 1'b1;
			ACT_ZONE_ON: begin
				if (busy_seq) status_d = ST_BUSY;
				else if (!ch_ok) status_d = ST_INVALID_CHANNEL;
				else if (!req_s1.system_ready) status_d = ST_NOT_READY;
				else if (active_cnt >= CNT_W'(MAX_ACTIVE) || req_s1.system_fault)
					status_d = ST_BUSY;
				else on_go = 1'b1;
			end
			ACT_ZONE_OFF: begin
				if (busy_seq) status_d = ST_BUSY;
				else if (!ch_ok) status_d = ST_INVALID_CHANNEL;
				else off_go = 1'b1;
			end
			ACT_CLOSE_ALL: begin
				if (busy_seq) status_d = ST_BUSY;
				else all_go = 1'b1;
			end
			ACT_NOTIFY_TASK: notify = 1'b1;
			ACT_CLEAR_TASK:  clear = 1'b1;
			ACT_MANUAL_OPEN, ACT_MANUAL_CLOSE: begin
				if (busy_seq) status_d = ST_BUSY;
				else if (!master_enable_q) status_d = ST_MASTER_DISABLED;
				else if (auto_manage_q) status_d = ST_BUSY;
				else if (req_s1.action == ACT_MANUAL_OPEN) man_open = 1'b1;
				else man_close = 1'b1;
			end
			default: ;
		endcase
		seq_fire = do_tick && busy_seq && (seq_deadline_q == um);
	end

	// sequence next state
	always_comb begin
		phase_d        = phase_q;
		seq_ch_d       = seq_ch_q;
		seq_deadline_d = seq_deadline_q;
		if (seq_fire) begin
			phase_d = PH_IDLE;
		end else if (on_go && automatic_mode && pre_pos) begin
			phase_d        = PH_ZONE_AFTER_MASTER;
			seq_ch_d       = ch_idx;
			seq_deadline_d = uptime_q + MS_W'(pre_ms);
		end else if (on_go && automatic_mode && pre_neg) begin
			phase_d        = PH_MASTER_AFTER_ZONE;
			seq_ch_d       = ch_idx;
			seq_deadline_d = uptime_q + MS_W'(pre_ms);
		end else if (off_go && automatic_mode && post_neg) begin
			phase_d        = PH_ZONE_AFTER_CLOSE;
			seq_ch_d       = ch_idx;
			seq_deadline_d = uptime_q + MS_W'(post_ms);
		end
	end

	// valve state update and result
	always_comb begin
		logic             off_run;
		logic [ZONES-1:0] off_bits;
		logic             pulse;
		uptime_d       = uptime_q;
		next_task_d    = next_task_q;
		task_pending_d = task_pending_q;
		zone_mask_d    = zone_mask_q;
		master_d       = master_q;
		armed_d        = armed_q;
		close_ms_d     = close_ms_q;
		off_run        = 1'b0;
		off_bits       = '0;
		pulse          = 1'b0;

		// tick: uptime, close check, timed sequence step
		if (do_tick) begin
			uptime_d = um;
			if (armed_q && (close_ms_q == um)) begin
				armed_d = 1'b0;
				if (fire_close) master_d = 1'b0;
			end
			if (seq_fire) begin
				case (phase_q)
					PH_ZONE_AFTER_MASTER: zone_mask_d = zone_mask_d | (ZONES'(1) << seq_ch_q);
					PH_MASTER_AFTER_ZONE: if (master_enable_q) master_d = 1'b1;
					PH_ZONE_AFTER_CLOSE: begin
						off_run  = 1'b1;
						off_bits = ZONES'(1) << seq_ch_q;
					end
					default: ;
				endcase
			end
		end

		// zone on
		if (on_go) begin
			if (automatic_mode && pre_pos) begin
				master_d = 1'b1;
			end else begin
				zone_mask_d = zone_mask_d | (ZONES'(1) << ch_idx);
				if (automatic_mode && !pre_neg) master_d = 1'b1;
			end
		end

		// zone off and close all
		if (off_go) begin
			if (automatic_mode && post_neg) begin
				master_d = 1'b0;
			end else begin
				off_run  = 1'b1;
				off_bits = ZONES'(1) << ch_idx;
			end
		end
		if (all_go) begin
			off_run  = 1'b1;
			off_bits = '1;
		end

		// last zone closed: in automatic mode close the master now or arm the close check
		if (off_run) begin
			zone_mask_d = zone_mask_d & ~off_bits;
			if (zone_mask_d == '0) begin
				pulse = 1'b1;
				if (automatic_mode) begin
					if (do_arm) begin
						if (!armed_d) begin
							if (arm_delay == '0) begin
								if (fire_close) master_d = 1'b0;
							end else begin
								armed_d    = 1'b1;
								close_ms_d = um + arm_delay;
							end
						end
					end else begin
						master_d = 1'b0;
					end
				end
			end
		end
		if (all_go && master_enable_q) master_d = 1'b0;

		// manual master control
		if (man_open) master_d = 1'b1;
		if (man_close) master_d = 1'b0;

		// task bookkeeping
		if (notify) begin
			next_task_d    = req_s1.task_start_ms;
			task_pending_d = 1'b1;
		end
		if (clear) begin
			next_task_d    = '0;
			task_pending_d = 1'b0;
		end

		rsp_d.status           = status_d;
		rsp_d.zone_open_mask   = 8'(zone_mask_d);
		rsp_d.master_open      = master_enable_q && master_d;
		rsp_d.watering         = (zone_mask_d != '0);
		rsp_d.clear_flow_count = pulse;
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_data;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	// valve and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uptime_q       <= '0;
			next_task_q    <= '0;
			task_pending_q <= 1'b0;
			zone_mask_q    <= '0;
			master_q       <= 1'b0;
			armed_q        <= 1'b0;
			close_ms_q     <= '0;
			phase_q        <= PH_IDLE;
			seq_ch_q       <= '0;
			seq_deadline_q <= '0;
		end else if (advance) begin
			uptime_q       <= uptime_d;
			next_task_q    <= next_task_d;
			task_pending_q <= task_pending_d;
			zone_mask_q    <= zone_mask_d;
			master_q       <= master_d;
			armed_q        <= armed_d;
			close_ms_q     <= close_ms_d;
			phase_q        <= phase_d;
			seq_ch_q       <= seq_ch_d;
			seq_deadline_q <= seq_deadline_d;
		end
	end

	// checks
	a_pulse_means_closed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.clear_flow_count |-> rsp_q.zone_open_mask == 8'd0)
		else $error("flow clear pulse with a zone open");

	a_watering_matches: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.watering == (rsp_q.zone_open_mask != 8'd0))
		else $error("watering flag disagrees with zone mask");

	a_active_limit: assert property (@(posedge clk) disable iff (!arst_n)
		active_cnt <= CNT_W'(MAX_ACTIVE))
		else $error("more zones open than allowed");

	a_tick_uptime: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.action == ACT_TICK |=> uptime_q == $past(uptime_q) + 32'd1)
		else $error("tick did not advance uptime");

	a_seq_only_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q != PH_IDLE && !seq_fire |=> phase_q == $past(phase_q))
		else $error("sequence step restarted while pending");

endmodule

// ----- tb/valve_checker.sv -----
`timescale 1ns / 1ps

module valve_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_ready,
	input  mzvs_pkg::req_item_t             req_data,
	input  logic                            rsp_valid,
	input  logic                            rsp_ready,
	input  mzvs_pkg::rsp_item_t             rsp_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [mzvs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mzvs_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              outstanding
);
	import mzvs_pkg::*;

	localparam int ZONE_COUNT   = 8;
	localparam int ACTIVE_LIMIT = 1;

	// shadow copy of the configuration registers
	logic              m_enable;
	logic              auto_mode;
	logic signed [8:0] pre_delay_s;
	logic signed [8:0] post_delay_s;
	logic [7:0]        grace_s;

	// shadow copy of the valve state
	logic [31:0] uptime;
	logic [7:0]  zones_open;
	int          active_zones;
	logic        main_valve_open;
	logic        task_pending;
	logic [31:0] task_at;
	logic        check_armed;
	logic [31:0] check_at;
	phase_t      phase;
	logic [2:0]  phase_zone;
	logic [31:0] phase_due;

	rsp_item_t   due_results[$];
	rsp_item_t   oldest;
	int          err_count;

	function automatic void reset_model();
		m_enable        = 1'b1;
		auto_mode       = 1'b1;
		pre_delay_s     = 9'sd3;
		post_delay_s    = 9'sd2;
		grace_s         = 8'd5;
		uptime          = '0;
		zones_open      = '0;
		active_zones    = 0;
		main_valve_open = 1'b0;
		task_pending    = 1'b0;
		task_at         = '0;
		check_armed     = 1'b0;
		check_at        = '0;
		phase           = PH_IDLE;
		phase_zone      = '0;
		phase_due       = '0;
	endfunction

	function automatic logic [31:0] secs_to_ms(input int s);
		return 32'((s < 0) ? -s : s) * 32'd1000;
	endfunction

	function automatic logic auto_on();
		return m_enable && auto_mode;
	endfunction

	// master valve only moves when it is present
	function automatic void master_set(input logic open_it);
		if (m_enable) main_valve_open = open_it;
	endfunction

	// close the master unless a task is pending and its start plus grace is not past
	function automatic void run_close_check();
		logic [31:0] limit;
		limit = task_at + 32'(grace_s) * 32'd1000;
		if (main_valve_open && (!task_pending || uptime > limit)) master_set(1'b0);
	endfunction

	// an armed check keeps its old deadline
	function automatic void arm_close_check(input logic [31:0] wait_ms);
		if (!check_armed) begin
			if (wait_ms == 0) begin
				run_close_check();
			end else begin
				check_armed = 1'b1;
				check_at    = uptime + wait_ms;
			end
		end
	endfunction

	function automatic void after_last_zone();
		int post;
		post = post_delay_s;
		if (post > 0) arm_close_check(secs_to_ms(post));
		else master_set(1'b0);
	endfunction

	function automatic void zone_open(input logic [2:0] z);
		if (!zones_open[z]) begin
			zones_open[z] = 1'b1;
			active_zones++;
		end
	endfunction

	// close one zone; returns the flow-count clear pulse
	function automatic logic zone_closed(input logic [2:0] z);
		logic [31:0] grace_ms;
		logic [31:0] lead_ms;
		if (zones_open[z]) begin
			zones_open[z] = 1'b0;
			if (active_zones > 0) active_zones--;
		end
		if (zones_open != 0) return 1'b0;
		if (auto_on()) begin
			if (task_pending) begin
				grace_ms = 32'(grace_s) * 32'd1000;
				lead_ms  = task_at - uptime;
				if (lead_ms <= grace_ms) arm_close_check(lead_ms + grace_ms);
				else after_last_zone();
			end else begin
				after_last_zone();
			end
		end
		return 1'b1;
	endfunction

	// next valve state and the result of one request
	function automatic rsp_item_t valve_step(input req_item_t item);
		rsp_item_t res;
		status_t   st;
		logic      pulse;
		logic      seq_busy;
		int        pre;
		int        post;
		int        z;
		st       = ST_OK;
		pulse    = 1'b0;
		seq_busy = (phase != PH_IDLE);
		pre      = pre_delay_s;
		post     = post_delay_s;
		if (seq_busy && item.action != ACT_TICK && item.action != ACT_NOTIFY_TASK &&
				item.action != ACT_CLEAR_TASK) begin
			st = ST_BUSY;
		end else begin
			case (item.action)
			ACT_TICK: begin
				uptime++;
				if (check_armed && check_at == uptime) begin
					check_armed = 1'b0;
					run_close_check();
				end
				if (seq_busy && phase_due == uptime) begin
					case (phase)
					PH_ZONE_AFTER_MASTER: zone_open(phase_zone);
					PH_MASTER_AFTER_ZONE: master_set(1'b1);
					default: pulse = zone_closed(phase_zone);
					endcase
					phase = PH_IDLE;
				end
			end
			ACT_ZONE_ON: begin
				if (item.channel >= ZONE_COUNT) begin
					st = ST_INVALID_CHANNEL;
				end else if (!item.system_ready) begin
					st = ST_NOT_READY;
				end else if (active_zones >= ACTIVE_LIMIT || item.system_fault) begin
					st = ST_BUSY;
				end else if (auto_on() && pre > 0) begin
					master_set(1'b1);
					phase      = PH_ZONE_AFTER_MASTER;
					phase_zone = item.channel[2:0];
					phase_due  = uptime + secs_to_ms(pre);
				end else begin
					zone_open(item.channel[2:0]);
					if (auto_on()) begin
						if (pre < 0) begin
							phase      = PH_MASTER_AFTER_ZONE;
							phase_zone = item.channel[2:0];
							phase_due  = uptime + secs_to_ms(pre);
						end else begin
							master_set(1'b1);
						end
					end
				end
			end
			ACT_ZONE_OFF: begin
				if (item.channel >= ZONE_COUNT) begin
					st = ST_INVALID_CHANNEL;
				end else if (auto_on() && post < 0) begin
					master_set(1'b0);
					phase      = PH_ZONE_AFTER_CLOSE;
					phase_zone = item.channel[2:0];
					phase_due  = uptime + secs_to_ms(post);
				end else begin
					pulse = zone_closed(item.channel[2:0]);
				end
			end
			ACT_CLOSE_ALL: begin
				for (z = 0; z < ZONE_COUNT; z++) begin
					if (auto_on() && post < 0) master_set(1'b0);
					pulse = zone_closed(3'(z));
				end
				master_set(1'b0);
			end
			ACT_NOTIFY_TASK: begin
				task_at      = item.task_start_ms;
				task_pending = 1'b1;
			end
			ACT_CLEAR_TASK: begin
				task_at      = '0;
				task_pending = 1'b0;
			end
			default: begin
				if (!m_enable) st = ST_MASTER_DISABLED;
				else if (auto_mode) st = ST_BUSY;
				else master_set(item.action == ACT_MANUAL_OPEN);
			end
			endcase
		end
		res.status           = st;
		res.zone_open_mask   = zones_open;
		res.master_open      = m_enable && main_valve_open;
		res.watering         = |zones_open;
		res.clear_flow_count = pulse;
		return res;
	endfunction

	task automatic match_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// predict on each request, compare each result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			due_results.delete();
			err_count = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_results.size() == 0) begin
					$error("result with no request waiting: %h", rsp_data);
					err_count++;
				end else begin
					oldest = due_results.pop_front();
					match_field("status", 8'(oldest.status), 8'(rsp_data.status));
					match_field("zone_open_mask", oldest.zone_open_mask,
						rsp_data.zone_open_mask);
					match_field("master_open", 8'(oldest.master_open),
						8'(rsp_data.master_open));
					match_field("watering", 8'(oldest.watering), 8'(rsp_data.watering));
					match_field("clear_flow_count", 8'(oldest.clear_flow_count),
						8'(rsp_data.clear_flow_count));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_MASTER_ENABLE: m_enable     = cfg_data[0];
				CFG_AUTO_MANAGE:   auto_mode    = cfg_data[0];
				CFG_PRE_START:     pre_delay_s  = cfg_data;
				CFG_POST_STOP:     post_delay_s = cfg_data;
				CFG_GRACE:         grace_s      = cfg_data[7:0];
				default: ;
				endcase
			end
			if (req_valid && req_ready) due_results.push_back(valve_step(req_data));
			errors      <= err_count;
			outstanding <= due_results.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import mzvs_pkg::*;

	localparam int QUIET_LIMIT = 5000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_item_t             req_data  = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_item_t             rsp_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int          errors;
	int          outstanding;
	int          idle_pct     = 0;
	int          stall_pct    = 0;
	int          quiet_cycles = 0;
	logic [31:0] ticks_sent   = '0;

	master_and_zone_valve_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	valve_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_data    (req_data),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp_data    (rsp_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// result side back-pressure
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one request, with random idle cycles ahead of it
	task automatic send_req(input req_item_t item);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (item.action == ACT_TICK) ticks_sent++;
	endtask

	task automatic issue(input action_t act, input logic [7:0] ch, input logic [31:0] start,
			input logic ready, input logic fault);
		req_item_t item;
		item.action        = act;
		item.channel       = ch;
		item.task_start_ms = start;
		item.system_ready  = ready;
		item.system_fault  = fault;
		send_req(item);
	endtask

	// mostly valid zones, task starts near the current uptime
	function automatic req_item_t random_item();
		req_item_t item;
		int        pick;
		item.channel      = ($urandom_range(99) < 85) ? 8'($urandom_range(7)) : 8'($urandom);
		item.system_ready = ($urandom_range(99) < 90);
		item.system_fault = ($urandom_range(99) < 10);
		pick = $urandom_range(99);
		if (pick < 30) item.action = ACT_TICK;
		else if (pick < 50) item.action = ACT_ZONE_ON;
		else if (pick < 68) item.action = ACT_ZONE_OFF;
		else if (pick < 73) item.action = ACT_CLOSE_ALL;
		else if (pick < 83) item.action = ACT_NOTIFY_TASK;
		else if (pick < 88) item.action = ACT_CLEAR_TASK;
		else if (pick < 94) item.action = ACT_MANUAL_OPEN;
		else item.action = ACT_MANUAL_CLOSE;
		pick = $urandom_range(9);
		if (pick < 5) item.task_start_ms = ticks_sent + $urandom_range(2500);
		else if (pick < 7) item.task_start_ms = ticks_sent - $urandom_range(2500);
		else item.task_start_ms = $urandom;
		return item;
	endfunction

	task automatic send_tick();
		req_item_t item;
		item        = random_item();
		item.action = ACT_TICK;
		send_req(item);
	endtask

	task automatic tick_burst(input int count);
		repeat (count) send_tick();
	endtask

	// stop sending and wait for every result
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic m_en, input logic auto_en, input int pre_s,
			input int post_s, input int grace);
		settle();
		write_cfg(CFG_MASTER_ENABLE, 9'(m_en));
		write_cfg(CFG_AUTO_MANAGE, 9'(auto_en));
		write_cfg(CFG_PRE_START, 9'(pre_s));
		write_cfg(CFG_POST_STOP, 9'(post_s));
		write_cfg(CFG_GRACE, 9'(grace));
	endtask

	// zone on, a few ticks, zone off or close all; slow rounds add longer tick runs
	task automatic water_cycle(input logic slow);
		req_item_t  item;
		logic [7:0] zone;
		zone = 8'($urandom_range(7));
		if ($urandom_range(3) == 0) begin
			item        = random_item();
			item.action = ACT_NOTIFY_TASK;
			send_req(item);
		end
		item              = random_item();
		item.action       = ACT_ZONE_ON;
		item.channel      = zone;
		item.system_ready = 1'b1;
		item.system_fault = 1'b0;
		send_req(item);
		repeat ($urandom_range(4)) send_tick();
		if (slow && $urandom_range(4) == 0) tick_burst($urandom_range(5, 15));
		item         = random_item();
		item.action  = ($urandom_range(4) == 0) ? ACT_CLOSE_ALL : ACT_ZONE_OFF;
		item.channel = zone;
		send_req(item);
		repeat ($urandom_range(4)) send_tick();
		if (slow && $urandom_range(4) == 0) tick_burst($urandom_range(5, 15));
	endtask

	task automatic run_phase(input int rounds, input logic slow);
		int pick;
		repeat (rounds) begin
			pick = $urandom_range(99);
			if (pick < 45) water_cycle(slow);
			else if (slow && pick < 48) tick_burst($urandom_range(5, 15));
			else if (pick < 50) settle();
			else send_req(random_item());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// immediate valves: refusals, limits, last-zone handling
		set_config(1'b1, 1'b1, 0, 0, 0);
		issue(ACT_TICK, 8'd0, 32'd0, 1'b1, 1'b0);
		issue(ACT_ZONE_ON, 8'd8, 32'd0, 1'b1, 1'b0);
		issue(ACT_ZONE_ON, 8'd255, 32'hFFFF_FFFF, 1'b1, 1'b1);
		issue(ACT_ZONE_ON, 8'd0, 32'd0, 1'b0, 1'b1);
		issue(ACT_ZONE_ON, 8'd0, 32'd0, 1'b1, 1'b1);
		issue(ACT_ZONE_ON, 8'd7, 32'd0, 1'b1, 1'b0);
		issue(ACT_ZONE_ON, 8'd3, 32'd0, 1'b1, 1'b0);
		issue(ACT_MANUAL_OPEN, 8'd0, 32'd0, 1'b1, 1'b0);
		issue(ACT_ZONE_OFF, 8'd200, 32'd0, 1'b1, 1'b0);
		issue(ACT_ZONE_OFF, 8'd3, 32'd0, 1'b1, 1'b0);
		issue(ACT_NOTIFY_TASK, 8'd0, ticks_sent, 1'b1, 1'b0);
		issue(ACT_ZONE_OFF, 8'd7, 32'd0, 1'b1, 1'b0);
		issue(ACT_ZONE_OFF, 8'd5, 32'd0, 1'b1, 1'b0);
		issue(ACT_CLEAR_TASK, 8'd0, 32'd0, 1'b1, 1'b0);
		issue(ACT_ZONE_ON, 8'd2, 32'd0, 1'b1, 1'b0);
		issue(ACT_CLOSE_ALL, 8'd0, 32'd0, 1'b1, 1'b0);
		issue(ACT_MANUAL_CLOSE, 8'd0, 32'd0, 1'b1, 1'b0);

		// manual master control, then no master at all
		set_config(1'b1, 1'b0, 0, 0, 0);
		issue(ACT_MANUAL_OPEN, 8'd0, 32'd0, 1'b1, 1'b0);
		issue(ACT_MANUAL_CLOSE, 8'd0, 32'd0, 1'b1, 1'b0);
		issue(ACT_MANUAL_OPEN, 8'd0, 32'd0, 1'b1, 1'b0);
		set_config(1'b0, 1'b0, 0, 0, 0);
		issue(ACT_MANUAL_OPEN, 8'd0, 32'd0, 1'b1, 1'b0);
		issue(ACT_MANUAL_CLOSE, 8'd0, 32'd0, 1'b1, 1'b0);

		// random traffic, no idling
		idle_pct  = 0;
		stall_pct = 0;
		set_config(1'b1, 1'b1, 0, 0, 0);
		run_phase(25, 1'b1);
		set_config(1'b1, 1'b0, -255, -255, 0);
		run_phase(25, 1'b0);

		// sender mostly idle
		idle_pct  = 79;
		stall_pct = 0;
		set_config(1'b0, 1'b1, 255, -255, 255);
		run_phase(25, 1'b1);
		set_config(1'b1, 1'b0, 3, 2, 5);
		run_phase(25, 1'b0);

		// receiver mostly stalling
		idle_pct  = 0;
		stall_pct = 79;
		set_config(1'b1, 1'b1, 0, 0, 0);
		run_phase(25, 1'b1);
		set_config(1'b0, 1'b0, -1, -1, 1);
		run_phase(25, 1'b0);

		// both sides idling now and then; close checks that stay armed come last
		idle_pct  = 16;
		stall_pct = 16;
		set_config(1'b1, 1'b1, 0, 0, 0);
		run_phase(25, 1'b1);
		set_config(1'b1, 1'b1, 0, 255, 255);
		run_phase(25, 1'b0);

		// timed steps: requests refused while a step is pending
		set_config(1'b1, 1'b1, 1, -1, 1);
		issue(ACT_CLOSE_ALL, 8'd0, 32'd0, 1'b1, 1'b0);
		issue(ACT_ZONE_ON, 8'd1, 32'd0, 1'b1, 1'b0);
		issue(ACT_ZONE_ON, 8'd2, 32'd0, 1'b1, 1'b0);
		issue(ACT_NOTIFY_TASK, 8'd0, ticks_sent + 32'd500, 1'b1, 1'b0);
		issue(ACT_CLEAR_TASK, 8'd0, 32'd0, 1'b1, 1'b0);
		tick_burst(20);
		issue(ACT_ZONE_OFF, 8'd1, 32'd0, 1'b1, 1'b0);
		issue(ACT_CLOSE_ALL, 8'd0, 32'd0, 1'b1, 1'b0);
		issue(ACT_MANUAL_CLOSE, 8'd0, 32'd0, 1'b1, 1'b0);
		tick_burst(20);

		settle();
		repeat (10) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ----- master_and_zone_valve_sequencer.f -----
hdl/mzvs_pkg.sv
hdl/master_and_zone_valve_sequencer.sv
tb/valve_checker.sv
tb/testbench.sv
